[src/lmrf_pkg.sv]
package lmrf_pkg;

    localparam int COLS   = 8;
    localparam int ROWS   = 8;
    localparam int NPIX   = COLS * ROWS;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = (NPIX > 1) ? $clog2(NPIX) : 1;

    typedef logic [23:0] pixel_t;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_RECT    = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_REFRESH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SIZE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_DONE,
        S_SCAN_RD,
        S_SCAN_LD
    } state_t;

    // write port bundle from the sequencer to the frame store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        pixel_t            data;
    } store_wr_t;

endpackage

[src/lmrf_store.sv]
// Frame store: one write port, one registered read port.
// Per-entry valid bits give the all-dark reset without a clearing pass.
module lmrf_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lmrf_pkg::store_wr_t        wr,
    input  logic                       rd_en,
    input  logic [lmrf_pkg::ADDR_W-1:0] rd_addr,
    output lmrf_pkg::pixel_t           rd_data
);

    lmrf_pkg::pixel_t            mem [lmrf_pkg::NPIX];
    logic [lmrf_pkg::NPIX-1:0]   vld_reg;
    lmrf_pkg::pixel_t            rd_q_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as dark
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

[src/led_matrix_rect_fill_and_scanout_unit.sv]
// A range or size error answers at the accept edge, which registers out_valid.
// Clear writes COLS*ROWS pixels, rect fill its clipped area, set pixel one, each one
// pixel per cycle through the store write port, then the done state posts the status.
// Refresh: a first read state, then one pixel per cycle (COLS*ROWS results) as
// the registered read port of the store allows, slower if the output stalls.
// Reset: asynchronous active-low; control clears, store reads back all dark.
module led_matrix_rect_fill_and_scanout_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [23:0] pixel_grb,
    output logic        last
);

    localparam int COL_W  = lmrf_pkg::COL_W;
    localparam int ROW_W  = lmrf_pkg::ROW_W;
    localparam int ADDR_W = lmrf_pkg::ADDR_W;

    // sequencer state
    lmrf_pkg::state_t state_reg, state_next;

    // fill walker: current pixel, row start column and inclusive end corner
    logic [COL_W-1:0]  x_reg, x_next;
    logic [COL_W-1:0]  x0_reg, x0_next;
    logic [COL_W-1:0]  xlast_reg, xlast_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [ROW_W-1:0]  ylast_reg, ylast_next;
    lmrf_pkg::pixel_t  colour_reg, colour_next;

    // scan-out address
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;

    // output register (the skid stage towards the consumer)
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    lmrf_pkg::pixel_t  pixel_reg, pixel_next;
    logic              last_reg, last_next;

    // store interface
    lmrf_pkg::store_wr_t wr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    lmrf_pkg::pixel_t    rd_data;

    // decode of the incoming request
    logic              accept;
    logic              slot_free;
    logic              pos_bad;
    logic              size_bad;
    logic [8:0]        x_sum;
    logic [8:0]        y_sum;
    logic [COL_W-1:0]  rect_xlast;
    logic [ROW_W-1:0]  rect_ylast;
    logic              fill_end;
    logic              scan_end;

    lmrf_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output slot can take a new result when empty or being drained now.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lmrf_pkg::S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign pos_bad  = (pos_x >= 8'(lmrf_pkg::COLS)) || (pos_y >= 8'(lmrf_pkg::ROWS));
    assign size_bad = (rect_width == 8'd0) || (rect_height == 8'd0);

    // Clip the rectangle at the right and bottom edges; the end corner is inclusive.
    assign x_sum = {1'b0, pos_x} + {1'b0, rect_width};
    assign y_sum = {1'b0, pos_y} + {1'b0, rect_height};
    assign rect_xlast = (x_sum >= 9'(lmrf_pkg::COLS)) ? COL_W'(lmrf_pkg::COLS - 1)
                                                      : COL_W'(x_sum - 9'd1);
    assign rect_ylast = (y_sum >= 9'(lmrf_pkg::ROWS)) ? ROW_W'(lmrf_pkg::ROWS - 1)
                                                      : ROW_W'(y_sum - 9'd1);

    assign fill_end = (x_reg == xlast_reg) && (y_reg == ylast_reg);
    assign scan_end = (scan_addr_reg == ADDR_W'(lmrf_pkg::NPIX - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmrf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (lmrf_pkg::opcode_t'(opcode))
                        lmrf_pkg::OP_CLEAR:
                        begin
                            state_next = lmrf_pkg::S_FILL;
                        end
                        lmrf_pkg::OP_RECT:
                        begin
                            if (!pos_bad && !size_bad)
                            begin
                                state_next = lmrf_pkg::S_FILL;
                            end
                        end
                        lmrf_pkg::OP_PIXEL:
                        begin
                            if (!pos_bad)
                            begin
                                state_next = lmrf_pkg::S_FILL;
                            end
                        end
                        default:
                        begin
                            state_next = lmrf_pkg::S_SCAN_RD;
                        end
                    endcase
                end
            end
            lmrf_pkg::S_FILL:
            begin
                if (fill_end)
                begin
                    state_next = lmrf_pkg::S_DONE;
                end
            end
            lmrf_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = lmrf_pkg::S_IDLE;
                end
            end
            lmrf_pkg::S_SCAN_RD:
            begin
                state_next = lmrf_pkg::S_SCAN_LD;
            end
            lmrf_pkg::S_SCAN_LD:
            begin
                if (slot_free && scan_end)
                begin
                    state_next = lmrf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lmrf_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        x_next         = x_reg;
        x0_next        = x0_reg;
        xlast_next     = xlast_reg;
        y_next         = y_reg;
        ylast_next     = ylast_reg;
        colour_next    = colour_reg;
        scan_addr_next = scan_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        pixel_next     = pixel_reg;
        last_next      = last_reg;
        wr.en          = 1'b0;
        wr.addr        = ADDR_W'(int'(y_reg) * lmrf_pkg::COLS + int'(x_reg));
        wr.data        = colour_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_addr_reg;

        case (state_reg)
            lmrf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    colour_next    = {green, red, blue};
                    scan_addr_next = '0;
                    case (lmrf_pkg::opcode_t'(opcode))
                        lmrf_pkg::OP_CLEAR:
                        begin
                            x_next     = '0;
                            x0_next    = '0;
                            y_next     = '0;
                            xlast_next = COL_W'(lmrf_pkg::COLS - 1);
                            ylast_next = ROW_W'(lmrf_pkg::ROWS - 1);
                        end
                        lmrf_pkg::OP_RECT:
                        begin
                            x_next     = pos_x[COL_W-1:0];
                            x0_next    = pos_x[COL_W-1:0];
                            y_next     = pos_y[ROW_W-1:0];
                            xlast_next = rect_xlast;
                            ylast_next = rect_ylast;
                            if (pos_bad || size_bad)
                            begin
                                // position error takes precedence over size
                                out_valid_next = 1'b1;
                                status_next    = pos_bad ? lmrf_pkg::STAT_RANGE
                                                         : lmrf_pkg::STAT_SIZE;
                                pixel_next     = '0;
                                last_next      = 1'b1;
                            end
                        end
                        lmrf_pkg::OP_PIXEL:
                        begin
                            x_next     = pos_x[COL_W-1:0];
                            x0_next    = pos_x[COL_W-1:0];
                            y_next     = pos_y[ROW_W-1:0];
                            xlast_next = pos_x[COL_W-1:0];
                            ylast_next = pos_y[ROW_W-1:0];
                            if (pos_bad)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = lmrf_pkg::STAT_RANGE;
                                pixel_next     = '0;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lmrf_pkg::S_FILL:
            begin
                // one pixel per cycle, row-major walk over the clipped area
                wr.en = 1'b1;
                if (!fill_end)
                begin
                    if (x_reg == xlast_reg)
                    begin
                        x_next = x0_reg;
                        y_next = y_reg + ROW_W'(1);
                    end
                    else
                    begin
                        x_next = x_reg + COL_W'(1);
                    end
                end
            end
            lmrf_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lmrf_pkg::STAT_OK;
                    pixel_next     = '0;
                    last_next      = 1'b1;
                end
            end
            lmrf_pkg::S_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            lmrf_pkg::S_SCAN_LD:
            begin
                // read data holds until the slot frees; next read issued on load
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lmrf_pkg::STAT_OK;
                    pixel_next     = rd_data;
                    last_next      = scan_end;
                    if (!scan_end)
                    begin
                        scan_addr_next = scan_addr_reg + ADDR_W'(1);
                        rd_en          = 1'b1;
                        rd_addr        = scan_addr_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmrf_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        x0_reg        <= x0_next;
        xlast_reg     <= xlast_next;
        y_reg         <= y_next;
        ylast_reg     <= ylast_next;
        colour_reg    <= colour_next;
        scan_addr_reg <= scan_addr_next;
        status_reg    <= status_next;
        pixel_reg     <= pixel_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pixel_grb = pixel_reg;
    assign last      = last_reg;

endmodule

[tb/sv/frame_store_checker.sv]
module frame_store_checker
    import lmrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [23:0] pixel_grb,
    input  logic        last,
    output int          fail_count,
    output int          pending_results,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t status;
        pixel_t  grb;
        logic    last;
    } result_t;

    pixel_t  shadow_store [NPIX];
    result_t expected_q [$];
    int      errors;
    int      checked;

    function automatic void push_result(status_t st, pixel_t grb, logic is_last);
        result_t res;
        res.status = st;
        res.grb    = grb;
        res.last   = is_last;
        expected_q.push_back(res);
    endfunction

    // shadow copy of the frame store; queues the answers one request causes
    function automatic void predict_request(opcode_t op, logic [7:0] x, logic [7:0] y,
                                            logic [7:0] w, logic [7:0] h, pixel_t colour);
        case (op)
            OP_CLEAR:
            begin
                foreach (shadow_store[i])
                    shadow_store[i] = colour;
                push_result(STAT_OK, '0, 1'b1);
            end
            OP_RECT:
            begin
                if (x >= COLS || y >= ROWS)
                    push_result(STAT_RANGE, '0, 1'b1);
                else if (w == 0 || h == 0)
                    push_result(STAT_SIZE, '0, 1'b1);
                else
                begin
                    // clipped at right and bottom edges
                    for (int row = int'(y); row < int'(y) + int'(h) && row < ROWS; row++)
                        for (int col = int'(x); col < int'(x) + int'(w) && col < COLS; col++)
                            shadow_store[row * COLS + col] = colour;
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_PIXEL:
            begin
                if (x >= COLS || y >= ROWS)
                    push_result(STAT_RANGE, '0, 1'b1);
                else
                begin
                    shadow_store[int'(y) * COLS + int'(x)] = colour;
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            default:
            begin
                for (int i = 0; i < NPIX; i++)
                    push_result(STAT_OK, shadow_store[i], i == NPIX - 1);
            end
        endcase
    endfunction

    function automatic void flag_mismatch(string field, logic [23:0] exp_val,
                                          logic [23:0] act_val);
        errors++;
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                 $time, field, exp_val, act_val);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            expected_q.delete();
            errors          = 0;
            checked         = 0;
            fail_count      <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            // result first: anything leaving now belongs to an older request
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_q.size() == 0)
                    flag_mismatch("unexpected result, status", 'x, 24'(status));
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (status !== exp_res.status)
                        flag_mismatch("status", 24'(exp_res.status), 24'(status));
                    if (pixel_grb !== exp_res.grb)
                        flag_mismatch("pixel_grb", exp_res.grb, pixel_grb);
                    if (last !== exp_res.last)
                        flag_mismatch("last", 24'(exp_res.last), 24'(last));
                end
            end
            if (in_valid && in_ready)
                predict_request(opcode_t'(opcode), pos_x, pos_y, rect_width, rect_height,
                                {green, red, blue});
            fail_count      <= errors;
            pending_results <= expected_q.size();
            results_checked <= checked;
        end
    end

endmodule

[tb/sv/led_matrix_rect_fill_and_scanout_unit_tb.sv]
module led_matrix_rect_fill_and_scanout_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmrf_pkg::*;

    localparam int RANDOM_REQUESTS = 137;
    // worst case is at most 142 refreshes x 64 pixels under the one-in-four stall pattern; leave plenty
    localparam int CYCLE_LIMIT     = 500_000;
    // every request answers, so after the last answer only a short quiet window
    localparam int TAIL_CYCLES     = 80;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [23:0] pixel_grb;
    logic        last;

    int fail_count;
    int pending_results;
    int results_checked;

    // sender burst state and per-command tallies for the summary
    int burst_left;
    int op_count [4];
    int cycle_count;

    // receiver stall pattern state
    int stall_mode;
    int stall_phase_left;

    led_matrix_rect_fill_and_scanout_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .pixel_grb   (pixel_grb),
        .last        (last)
    );

    // watches both channels, keeps a shadow frame store and compares results
    frame_store_checker store_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .rect_width      (rect_width),
        .rect_height     (rect_height),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .pixel_grb       (pixel_grb),
        .last            (last),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    // Receiver: switches between stall patterns, each held for a random phase.
    //   mode 0 always ready, mode 1 random 60%, mode 2 one cycle in four,
    //   mode 3 mostly ready with rare stalls.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(16, 120);
        end
        else
            stall_phase_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 99) < 60);
            2:       out_ready <= (stall_phase_left % 4 == 0);
            default: out_ready <= ($urandom_range(0, 99) < 90);
        endcase
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still outstanding",
                     $time, cycle_count, pending_results);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sends one request. A new burst starts with a random gap (sometimes none),
    // during which valid drops. Valid is only raised again in a later step, so
    // valid never sees two nonblocking writes in one time step.
    task automatic issue_request(input opcode_t op, input logic [7:0] x, input logic [7:0] y,
                                 input logic [7:0] w, input logic [7:0] h,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        pos_x       <= x;
        pos_y       <= y;
        rect_width  <= w;
        rect_height <= h;
        red         <= r;
        green       <= g;
        blue        <= b;
        // hold until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        op_count[int'(op)]++;
    endtask

    // mostly near the display, now and then anywhere in the byte
    function automatic logic [7:0] pick_coord(int span);
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, span + 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly small rectangles, some zero, some huge
    function automatic logic [7:0] pick_extent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 8'($urandom_range(1, 9));
        if (roll < 80)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int      roll;
        opcode_t op;

        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        out_ready        = 1'b0;
        opcode           = OP_CLEAR;
        pos_x            = '0;
        pos_y            = '0;
        rect_width       = '0;
        rect_height      = '0;
        red              = '0;
        green            = '0;
        blue             = '0;
        burst_left       = 0;
        cycle_count      = 0;
        stall_mode       = 0;
        stall_phase_left = 0;
        foreach (op_count[i])
            op_count[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed part ----
        // store is dark straight out of reset
        issue_request(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        issue_request(OP_CLEAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'hFF);
        // one-pixel rectangle in the corner
        issue_request(OP_RECT,    8'h00, 8'h00, 8'h01, 8'h01, 8'hFF, 8'h00, 8'h00);
        // bottom-right corner with huge size: clipped down to one pixel
        issue_request(OP_RECT,    8'h07, 8'h07, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
        issue_request(OP_RECT,    8'h02, 8'h03, 8'h04, 8'h02, 8'h00, 8'h00, 8'hFF);
        // runs past the right edge
        issue_request(OP_RECT,    8'h05, 8'h00, 8'hC8, 8'h03, 8'h55, 8'hAA, 8'h5A);
        // position out of range in x, in y, and ahead of a zero size
        issue_request(OP_RECT,    8'h08, 8'h00, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_RECT,    8'h00, 8'hFF, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_RECT,    8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        // zero width, zero height
        issue_request(OP_RECT,    8'h01, 8'h01, 8'h00, 8'h05, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_RECT,    8'h01, 8'h01, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_PIXEL,   8'h00, 8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56);
        issue_request(OP_PIXEL,   8'h07, 8'h07, 8'h00, 8'h00, 8'hFE, 8'hDC, 8'hBA);
        issue_request(OP_PIXEL,   8'h08, 8'h03, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_PIXEL,   8'h03, 8'hFF, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF);
        // size fields do not matter for a single pixel
        issue_request(OP_PIXEL,   8'h04, 8'h04, 8'h00, 8'h00, 8'h80, 8'h01, 8'h7F);
        issue_request(OP_REFRESH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // clear ignores position and size
        issue_request(OP_CLEAR,   8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        issue_request(OP_RECT,    8'h00, 8'h00, 8'h08, 8'h08, 8'hA5, 8'h5A, 8'h3C);
        issue_request(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        issue_request(OP_CLEAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        issue_request(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        // ---- random part ----
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                op = OP_REFRESH;
            else if (roll < 30)
                op = OP_CLEAR;
            else if (roll < 70)
                op = OP_RECT;
            else
                op = OP_PIXEL;
            issue_request(op, pick_coord(COLS), pick_coord(ROWS), pick_extent(),
                          pick_extent(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        // final refresh so the last drawing is read back
        issue_request(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        in_valid <= 1'b0;

        // drain: the checker count already includes the last accepted request
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d clears, %0d rectangle fills, %0d set pixels, %0d refreshes;",
                 op_count[OP_CLEAR], op_count[OP_RECT], op_count[OP_PIXEL],
                 op_count[OP_REFRESH]);
        $display("checked %0d results with %0d mismatches under random stalls.",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
